### hw/rtl/qrs_pkg.sv
// Shared widths and status codes for the quadratic root solver.
package qrs_pkg;

  localparam int COEF_W = 16;
  localparam int DISC_W = 34;            // b*b - 4ac, signed
  localparam int SQRT_W = DISC_W / 2;    // one root bit per sqrt stage
  localparam int NUM_W  = 33;            // |num| << 16, one quotient bit per stage
  localparam int DEN_W  = 17;            // |2a|
  localparam int ROOT_W = 32;

  localparam logic [1:0] STAT_NONE   = 2'd0;
  localparam logic [1:0] STAT_ONE    = 2'd1;
  localparam logic [1:0] STAT_TWO    = 2'd2;
  localparam logic [1:0] STAT_ZERO_A = 2'd3;

endpackage

### hw/rtl/qrs_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module qrs_sqrt
  import qrs_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [DISC_W-1:0] d_in,
  output logic [SQRT_W-1:0] root
);

  logic [SQRT_W+1:0] rem   [SQRT_W];
  logic [SQRT_W-1:0] part  [SQRT_W];
  logic [DISC_W-1:0] rest  [SQRT_W];

  logic [SQRT_W+1:0] rem_next  [SQRT_W];
  logic [SQRT_W-1:0] part_next [SQRT_W];
  logic [DISC_W-1:0] rest_next [SQRT_W];

  logic [SQRT_W+1:0] prev_rem  [SQRT_W];
  logic [SQRT_W-1:0] prev_part [SQRT_W];
  logic [DISC_W-1:0] prev_rest [SQRT_W];
  logic [SQRT_W+3:0] shifted   [SQRT_W];
  logic [SQRT_W+3:0] trial     [SQRT_W];

  always_comb begin
    for (int i = 0; i < SQRT_W; i++) begin
      if (i == 0) begin
        prev_rem[i]  = '0;
        prev_part[i] = '0;
        prev_rest[i] = d_in;
      end else begin
        prev_rem[i]  = rem[i-1];
        prev_part[i] = part[i-1];
        prev_rest[i] = rest[i-1];
      end
      // bring down the next two bits, try (2q << 1) | 1
      shifted[i] = {prev_rem[i], prev_rest[i][DISC_W-1 -: 2]};
      trial[i]   = {2'b00, prev_part[i], 2'b01};
      rest_next[i] = {prev_rest[i][DISC_W-3:0], 2'b00};
      if (shifted[i] >= trial[i]) begin
        rem_next[i]  = SQRT_W'(0) + (SQRT_W+2)'(shifted[i] - trial[i]);
        part_next[i] = {prev_part[i][SQRT_W-2:0], 1'b1};
      end else begin
        rem_next[i]  = shifted[i][SQRT_W+1:0];
        part_next[i] = {prev_part[i][SQRT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < SQRT_W; i++) begin
        rem[i]  <= rem_next[i];
        part[i] <= part_next[i];
        rest[i] <= rest_next[i];
      end
    end
  end

  assign root = part[SQRT_W-1];

endmodule

### hw/rtl/qrs_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
module qrs_div
  import qrs_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num_in,
  input  logic [DEN_W-1:0] den_in,
  output logic [NUM_W-1:0] quo
);

  logic [DEN_W-1:0] rem [NUM_W];
  logic [NUM_W-1:0] dvd [NUM_W];
  logic [NUM_W-1:0] qac [NUM_W];
  logic [DEN_W-1:0] den [NUM_W];

  logic [DEN_W-1:0] rem_next [NUM_W];
  logic [NUM_W-1:0] dvd_next [NUM_W];
  logic [NUM_W-1:0] qac_next [NUM_W];
  logic [DEN_W-1:0] den_next [NUM_W];

  logic [DEN_W-1:0] prev_rem [NUM_W];
  logic [NUM_W-1:0] prev_dvd [NUM_W];
  logic [NUM_W-1:0] prev_qac [NUM_W];
  logic [DEN_W:0]   shifted  [NUM_W];

  always_comb begin
    for (int i = 0; i < NUM_W; i++) begin
      if (i == 0) begin
        prev_rem[i]  = '0;
        prev_dvd[i]  = num_in;
        prev_qac[i]  = '0;
        den_next[i]  = den_in;
      end else begin
        prev_rem[i]  = rem[i-1];
        prev_dvd[i]  = dvd[i-1];
        prev_qac[i]  = qac[i-1];
        den_next[i]  = den[i-1];
      end
      shifted[i]  = {prev_rem[i], prev_dvd[i][NUM_W-1]};
      dvd_next[i] = {prev_dvd[i][NUM_W-2:0], 1'b0};
      if (shifted[i] >= {1'b0, den_next[i]}) begin
        rem_next[i] = DEN_W'(shifted[i] - {1'b0, den_next[i]});
        qac_next[i] = {prev_qac[i][NUM_W-2:0], 1'b1};
      end else begin
        rem_next[i] = shifted[i][DEN_W-1:0];
        qac_next[i] = {prev_qac[i][NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_W; i++) begin
        rem[i] <= rem_next[i];
        dvd[i] <= dvd_next[i];
        qac[i] <= qac_next[i];
        den[i] <= den_next[i];
      end
    end
  end

  assign quo = qac[NUM_W-1];

endmodule

### hw/rtl/quadratic_root_solver_core.sv
// Top level of the quadratic root solver pipeline.
//
// Input channel: coef_a, coef_b, coef_c (signed Q8.8) with in_valid/in_ready.
// Output channel: status, root_first, root_second (signed Q16.16) with
// out_valid/out_ready. One result beat per input beat, in order.
//
// Pipeline: products, discriminant, 17 square-root stages (one root bit
// each), numerator forming, 33 divider stages (one quotient bit each, two
// dividers side by side for the two roots), then saturation into the output
// register. Throughput is one beat per cycle while the output register is
// not stalled; the divider chain sets the depth.
//
// The whole pipeline advances together. When the output register holds a
// beat that is not taken, every stage holds and in_ready drops; nothing is
// lost or repeated. Synchronous reset clears every valid bit; the pipeline
// is empty and in_ready is high after reset.
module quadratic_root_solver_core
  import qrs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [COEF_W-1:0] coef_a,
  input  logic signed [COEF_W-1:0] coef_b,
  input  logic signed [COEF_W-1:0] coef_c,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               status,
  output logic signed [ROOT_W-1:0] root_first,
  output logic signed [ROOT_W-1:0] root_second
);

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // products
  logic                     mul_v;
  logic signed [COEF_W-1:0] mul_a, mul_b;
  logic signed [2*COEF_W-1:0] mul_bb, mul_ac;

  // discriminant
  logic                     dsc_v;
  logic signed [COEF_W-1:0] dsc_a, dsc_b;
  logic [1:0]               dsc_st;
  logic [DISC_W-1:0]        dsc_rad;
  logic signed [DISC_W-1:0] disc_next;
  logic [1:0]               st_next;

  always_comb begin
    disc_next = DISC_W'(mul_bb) - (DISC_W'(mul_ac) <<< 2);
    if (mul_a == '0) begin
      st_next = STAT_ZERO_A;
    end else if (disc_next[DISC_W-1]) begin
      st_next = STAT_NONE;
    end else if (disc_next == '0) begin
      st_next = STAT_ONE;
    end else begin
      st_next = STAT_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_v <= 1'b0;
      dsc_v <= 1'b0;
    end else if (en) begin
      mul_v <= in_valid;
      dsc_v <= mul_v;
    end
    if (en) begin
      mul_a   <= coef_a;
      mul_b   <= coef_b;
      mul_bb  <= coef_b * coef_b;
      mul_ac  <= coef_a * coef_c;
      dsc_a   <= mul_a;
      dsc_b   <= mul_b;
      dsc_st  <= st_next;
      dsc_rad <= disc_next[DISC_W-1] ? '0 : disc_next;
    end
  end

  // square root with side data
  logic [SQRT_W-1:0]        sq_root;
  logic                     sq_v  [SQRT_W];
  logic signed [COEF_W-1:0] sq_a  [SQRT_W];
  logic signed [COEF_W-1:0] sq_b  [SQRT_W];
  logic [1:0]               sq_st [SQRT_W];

  qrs_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .d_in (dsc_rad),
    .root (sq_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SQRT_W; i++) sq_v[i] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= dsc_v;
      for (int i = 1; i < SQRT_W; i++) sq_v[i] <= sq_v[i-1];
    end
    if (en) begin
      sq_a[0]  <= dsc_a;
      sq_b[0]  <= dsc_b;
      sq_st[0] <= dsc_st;
      for (int i = 1; i < SQRT_W; i++) begin
        sq_a[i]  <= sq_a[i-1];
        sq_b[i]  <= sq_b[i-1];
        sq_st[i] <= sq_st[i-1];
      end
    end
  end

  // numerators -b +/- s, magnitudes and quotient signs
  logic signed [SQRT_W:0] neg_b, num1, num2;
  logic [SQRT_W:0]        mag1, mag2;
  logic [DEN_W-1:0]       abs_a;
  logic                   nm_v, nm_neg1, nm_neg2;
  logic [1:0]             nm_st;
  logic [NUM_W-1:0]       nm_n1, nm_n2;
  logic [DEN_W-1:0]       nm_den;

  always_comb begin
    neg_b = -((SQRT_W+1)'(sq_b[SQRT_W-1]));
    num1  = neg_b + $signed({1'b0, sq_root});
    num2  = neg_b - $signed({1'b0, sq_root});
    mag1  = num1[SQRT_W] ? (SQRT_W+1)'(-num1) : num1;
    mag2  = num2[SQRT_W] ? (SQRT_W+1)'(-num2) : num2;
    abs_a = sq_a[SQRT_W-1][COEF_W-1] ? DEN_W'(-(DEN_W'(sq_a[SQRT_W-1])))
                                     : DEN_W'(sq_a[SQRT_W-1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nm_v <= 1'b0;
    end else if (en) begin
      nm_v <= sq_v[SQRT_W-1];
    end
    if (en) begin
      nm_st   <= sq_st[SQRT_W-1];
      nm_neg1 <= num1[SQRT_W] ^ sq_a[SQRT_W-1][COEF_W-1];
      nm_neg2 <= num2[SQRT_W] ^ sq_a[SQRT_W-1][COEF_W-1];
      nm_n1   <= {mag1[SQRT_W-1:0], 16'h0000};
      nm_n2   <= {mag2[SQRT_W-1:0], 16'h0000};
      nm_den  <= {abs_a[DEN_W-2:0], 1'b0};
    end
  end

  // dividers with side data
  logic [NUM_W-1:0] quo1, quo2;
  logic             dv_v    [NUM_W];
  logic [1:0]       dv_st   [NUM_W];
  logic             dv_neg1 [NUM_W];
  logic             dv_neg2 [NUM_W];

  qrs_div u_div_first (
    .clk    (clk),
    .en     (en),
    .num_in (nm_n1),
    .den_in (nm_den),
    .quo    (quo1)
  );

  qrs_div u_div_second (
    .clk    (clk),
    .en     (en),
    .num_in (nm_n2),
    .den_in (nm_den),
    .quo    (quo2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_W; i++) dv_v[i] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= nm_v;
      for (int i = 1; i < NUM_W; i++) dv_v[i] <= dv_v[i-1];
    end
    if (en) begin
      dv_st[0]   <= nm_st;
      dv_neg1[0] <= nm_neg1;
      dv_neg2[0] <= nm_neg2;
      for (int i = 1; i < NUM_W; i++) begin
        dv_st[i]   <= dv_st[i-1];
        dv_neg1[i] <= dv_neg1[i-1];
        dv_neg2[i] <= dv_neg2[i-1];
      end
    end
  end

  // truncated magnitude plus sign, clamped to Q16.16
  function automatic logic [ROOT_W-1:0] saturate(input logic [NUM_W-1:0] q,
                                                 input logic neg);
    logic [NUM_W-1:0] lim;
    lim = NUM_W'(33'h0_8000_0000);
    if (neg) begin
      saturate = (q > lim) ? 32'h8000_0000 : ROOT_W'(-q);
    end else begin
      saturate = (q >= lim) ? 32'h7FFF_FFFF : q[ROOT_W-1:0];
    end
  endfunction

  logic [1:0]        fin_st;
  logic [ROOT_W-1:0] r1_next, r2_next;

  always_comb begin
    fin_st  = dv_st[NUM_W-1];
    r1_next = '0;
    r2_next = '0;
    if (fin_st == STAT_ONE || fin_st == STAT_TWO) begin
      r1_next = saturate(quo1, dv_neg1[NUM_W-1]);
    end
    if (fin_st == STAT_TWO) begin
      r2_next = saturate(quo2, dv_neg2[NUM_W-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_v[NUM_W-1];
    end
    if (en) begin
      status      <= fin_st;
      root_first  <= r1_next;
      root_second <= r2_next;
    end
  end

endmodule

### hw/rtl/qrs_check.sv
// Port-level checker for the quadratic root solver, bound to the top level.
module qrs_check
  import qrs_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [31:0] root_first,
  input logic [31:0] root_second
);

  a_no_root_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_NONE || status == STAT_ZERO_A)
      |-> root_first == '0 && root_second == '0)
    else $error("roots not zero without real roots");

  a_one_root_second_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_ONE |-> root_second == '0)
    else $error("second root set for repeated root");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status)
      && $stable(root_first) && $stable(root_second))
    else $error("stalled result beat changed");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result beat right after reset");

endmodule

bind quadratic_root_solver_core qrs_check u_qrs_check (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .root_first  (root_first),
  .root_second (root_second)
);
